[hdl/ibp_pkg.sv]
// ----------------------------------------------------------------------------
// ibp_pkg
// Shared constants, command codes, controller commands and the border
// index mapping used by the image border padder.
// ----------------------------------------------------------------------------
package ibp_pkg;

  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLS    = 64;
  localparam int PIXEL_WIDTH = 16;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int CFG_W       = 7;
  localparam int POS_W       = 8;
  localparam int IDX_W       = 3;

  localparam logic [CFG_W-1:0] ROWS_LIMIT = CFG_W'(MAX_ROWS);
  localparam logic [CFG_W-1:0] COLS_LIMIT = CFG_W'(MAX_COLS);
  localparam logic [CFG_W-1:0] PAD_LIMIT  = 7'd64;

  localparam logic [IDX_W-1:0] REG_IMAGE_ROWS  = 3'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_COLS  = 3'd1;
  localparam logic [IDX_W-1:0] REG_PAD_TOP     = 3'd2;
  localparam logic [IDX_W-1:0] REG_PAD_BOTTOM  = 3'd3;
  localparam logic [IDX_W-1:0] REG_PAD_LEFT    = 3'd4;
  localparam logic [IDX_W-1:0] REG_PAD_RIGHT   = 3'd5;
  localparam logic [IDX_W-1:0] REG_MIRROR_MODE = 3'd6;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic load;
    logic read;
    logic out_load;
  } ibp_cmd_t;

  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] clamp_pad(input logic [CFG_W-1:0] v);
    return (v > PAD_LIMIT) ? PAD_LIMIT : v;
  endfunction

  // Source index along one axis with edge-duplicating reflection
  function automatic logic [POS_W-1:0] src_index(input logic [POS_W-1:0] pos,
                                                 input logic [CFG_W-1:0] pad,
                                                 input logic [CFG_W-1:0] n);
    logic [POS_W-1:0] pad_w;
    logic [POS_W-1:0] n_w;
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] d;
    logic [POS_W-1:0] r;
    pad_w = POS_W'(pad);
    n_w   = POS_W'(n);
    p     = pos - pad_w;
    if (pos < pad_w) begin
      d = pad_w - POS_W'(1) - pos;
      r = (d >= n_w) ? n_w - POS_W'(1) : d;
    end else if (p < n_w) begin
      r = p;
    end else begin
      d = p - n_w;
      r = (d >= n_w) ? '0 : n_w - POS_W'(1) - d;
    end
    return r;
  endfunction

endpackage

[hdl/ibp_ctrl.sv]
// ----------------------------------------------------------------------------
// ibp_ctrl
// Handshake controller: accepts transactions, sequences the frame store
// read and owns the output register valid flag.
// ----------------------------------------------------------------------------
module ibp_ctrl
  import ibp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     command,
  output logic     out_valid,
  input  logic     out_ready,
  output ibp_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state;
  logic state_next;
  logic accept;
  logic slot_free;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  assign cmd.load     = accept && (command == CMD_LOAD);
  assign cmd.read     = accept && (command == CMD_READ);
  assign cmd.out_load = (state == S_READ) && slot_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.read) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hdl/ibp_datapath.sv]
// ----------------------------------------------------------------------------
// ibp_datapath
// Configuration registers, frame store, load counter, emit position,
// border address mapping and output register.
// ----------------------------------------------------------------------------
module ibp_datapath
  import ibp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  ibp_cmd_t               cmd,
  input  logic                   wr_en,
  input  logic [IDX_W-1:0]       wr_index,
  input  logic [CFG_W-1:0]       wr_data,
  input  logic [PIXEL_WIDTH-1:0] pixel_in,
  output logic [PIXEL_WIDTH-1:0] pixel_out,
  output logic [POS_W-1:0]       out_row,
  output logic [POS_W-1:0]       out_col,
  output logic                   frame_last,
  output logic                   not_ready
);

  logic [CFG_W-1:0] image_rows;
  logic [CFG_W-1:0] image_cols;
  logic [CFG_W-1:0] pad_top;
  logic [CFG_W-1:0] pad_bottom;
  logic [CFG_W-1:0] pad_left;
  logic [CFG_W-1:0] pad_right;
  logic             mirror_mode;

  logic [CFG_W-1:0] rows;
  logic [CFG_W-1:0] cols;
  logic [CFG_W-1:0] top;
  logic [CFG_W-1:0] left;
  logic [CNT_W-1:0] total;
  logic [POS_W-1:0] prow;
  logic [POS_W-1:0] pcol;

  logic [CNT_W-1:0] load_count;
  logic [POS_W-1:0] emit_row;
  logic [POS_W-1:0] emit_col;
  logic [POS_W-1:0] col_inc;
  logic [POS_W-1:0] row_inc;
  logic             wrap;
  logic             last;
  logic             loaded;

  logic [POS_W-1:0] sr;
  logic [POS_W-1:0] sc;
  logic             row_in;
  logic             col_in;
  logic [CNT_W-1:0] rd_sum;
  logic [ADDR_W-1:0] rd_addr;

  logic [PIXEL_WIDTH-1:0] store [STORE_DEPTH];
  logic [PIXEL_WIDTH-1:0] mem_q;

  logic             st_zero;
  logic             st_nr;
  logic             st_last;
  logic [POS_W-1:0] st_row;
  logic [POS_W-1:0] st_col;

  assign rows  = clamp_size(image_rows, ROWS_LIMIT);
  assign cols  = clamp_size(image_cols, COLS_LIMIT);
  assign top   = clamp_pad(pad_top);
  assign left  = clamp_pad(pad_left);
  assign total = CNT_W'(rows) * CNT_W'(cols);
  assign prow  = POS_W'(rows) + POS_W'(top) + POS_W'(clamp_pad(pad_bottom));
  assign pcol  = POS_W'(cols) + POS_W'(left) + POS_W'(clamp_pad(pad_right));

  assign loaded  = (load_count >= total);
  assign col_inc = emit_col + POS_W'(1);
  assign row_inc = emit_row + POS_W'(1);
  assign wrap    = (col_inc >= pcol);
  assign last    = wrap && (row_inc >= prow);

  assign sr     = src_index(emit_row, top, rows);
  assign sc     = src_index(emit_col, left, cols);
  assign row_in = (emit_row >= POS_W'(top)) && (emit_row - POS_W'(top) < POS_W'(rows));
  assign col_in = (emit_col >= POS_W'(left)) && (emit_col - POS_W'(left) < POS_W'(cols));
  assign rd_sum  = CNT_W'(sr) * CNT_W'(cols) + CNT_W'(sc);
  assign rd_addr = rd_sum[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows  <= ROWS_LIMIT;
      image_cols  <= COLS_LIMIT;
      pad_top     <= '0;
      pad_bottom  <= '0;
      pad_left    <= '0;
      pad_right   <= '0;
      mirror_mode <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_IMAGE_ROWS:  image_rows  <= wr_data;
        REG_IMAGE_COLS:  image_cols  <= wr_data;
        REG_PAD_TOP:     pad_top     <= wr_data;
        REG_PAD_BOTTOM:  pad_bottom  <= wr_data;
        REG_PAD_LEFT:    pad_left    <= wr_data;
        REG_PAD_RIGHT:   pad_right   <= wr_data;
        REG_MIRROR_MODE: mirror_mode <= wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      emit_row   <= '0;
      emit_col   <= '0;
    end else if (cmd.load && !loaded) begin
      load_count <= load_count + CNT_W'(1);
    end else if (cmd.read && loaded) begin
      if (last) begin
        load_count <= '0;
        emit_row   <= '0;
        emit_col   <= '0;
      end else if (wrap) begin
        emit_row <= row_inc;
        emit_col <= '0;
      end else begin
        emit_col <= col_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !loaded) begin
      store[load_count[ADDR_W-1:0]] <= pixel_in;
    end
    if (cmd.read) begin
      mem_q <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      st_nr   <= !loaded;
      st_zero <= !loaded || (!mirror_mode && !(row_in && col_in));
      st_last <= loaded && last;
      st_row  <= loaded ? emit_row : '0;
      st_col  <= loaded ? emit_col : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pixel_out  <= st_zero ? '0 : mem_q;
      out_row    <= st_row;
      out_col    <= st_col;
      frame_last <= st_last;
      not_ready  <= st_nr;
    end
  end

endmodule

[hdl/image_border_padder_top.sv]
// ----------------------------------------------------------------------------
// image_border_padder_top
// Frame store with zero or mirror border padding.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) carries a command and a pixel.
// A load command writes the next source pixel in raster order; loads past a
// full frame are dropped and produce no output. A read command produces one
// output transaction (out_valid/out_ready) with the next padded pixel and its
// row and column; frame_last marks the final pixel, after which the block
// rearms for a new frame. A read before the frame is complete returns
// not_ready with all other fields zero and changes nothing.
// Sequencing: loads are accepted back to back while the input is open. A
// read closes the input: the frame store read is registered when the read
// is accepted, then the output register is loaded from it once the output
// slot is free (empty, or being taken by the receiver), and the input reopens.
// Stall: while the output register is full and out_ready is low, loads are
// still taken, and a further read holds in_ready low until the slot frees.
// Reset: sizes 64x64, pads 0, zero mode, empty frame. Configuration must be
// written via wr_en/wr_index/wr_data while idle; the block does not check it.
// ----------------------------------------------------------------------------
module image_border_padder_top
  import ibp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [IDX_W-1:0]       wr_index,
  input  logic [CFG_W-1:0]       wr_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   command,
  input  logic [PIXEL_WIDTH-1:0] pixel_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [PIXEL_WIDTH-1:0] pixel_out,
  output logic [POS_W-1:0]       out_row,
  output logic [POS_W-1:0]       out_col,
  output logic                   frame_last,
  output logic                   not_ready
);

  ibp_cmd_t cmd;

  ibp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ibp_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .pixel_in   (pixel_in),
    .pixel_out  (pixel_out),
    .out_row    (out_row),
    .out_col    (out_col),
    .frame_last (frame_last),
    .not_ready  (not_ready)
  );

  a_read_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && command == CMD_READ) |=> !in_ready)
    else $error("input still open after read transaction");

  a_out_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("output register loaded without valid");

  a_not_ready_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && not_ready) |->
      (pixel_out == '0 && out_row == '0 && out_col == '0 && !frame_last))
    else $error("not_ready result carries nonzero fields");

endmodule

[tb/sv/image_border_padder_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_border_padder_top_test
// Loads source frames and reads back the padded image, in zero and mirror
// mode, and checks every output transaction against a scoreboard that keeps
// its own frame store, load count and emit position. Covers reads before the
// frame is loaded, dropped extra loads, out-of-range sizes and pads, pads
// wider than the image, and configuration changes in the middle of a frame.
// Traffic on both channels idles and stalls at random.
// ----------------------------------------------------------------------------
module image_border_padder_top_test;
  import ibp_pkg::*;

  typedef struct packed {
    logic [PIXEL_WIDTH-1:0] pixel;
    logic [POS_W-1:0]       row;
    logic [POS_W-1:0]       col;
    logic                   last;
    logic                   early;
  } padded_pixel_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_HEAVY} stall_mode_t;

  class pad_scoreboard;
    logic [PIXEL_WIDTH-1:0] store [STORE_DEPTH];
    int unsigned fill = 0;
    int unsigned cur_row = 0;
    int unsigned cur_col = 0;
    int unsigned rows_reg = MAX_ROWS;
    int unsigned cols_reg = MAX_COLS;
    int unsigned top_reg = 0;
    int unsigned bottom_reg = 0;
    int unsigned left_reg = 0;
    int unsigned right_reg = 0;
    bit mirror_reg = 0;
    padded_pixel_t pending[$];
    int errors = 0;
    int frames_done = 0;
    int effective_items = 0;

    function int unsigned sat(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned pixel_total();
      return sat(rows_reg, 1, MAX_ROWS) * sat(cols_reg, 1, MAX_COLS);
    endfunction

    function bit frame_loaded();
      return fill >= pixel_total();
    endfunction

    // Reflect a padded position back into the image, edge duplicated
    function int unsigned reflect(int unsigned pos, int unsigned pad, int unsigned n);
      int unsigned d;
      if (pos < pad) begin
        d = pad - 1 - pos;
        return (d >= n) ? n - 1 : d;
      end
      if (pos - pad < n) return pos - pad;
      d = pos - pad - n;
      return (d >= n) ? 0 : n - 1 - d;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_IMAGE_ROWS:  rows_reg = val;
        REG_IMAGE_COLS:  cols_reg = val;
        REG_PAD_TOP:     top_reg = val;
        REG_PAD_BOTTOM:  bottom_reg = val;
        REG_PAD_LEFT:    left_reg = val;
        REG_PAD_RIGHT:   right_reg = val;
        REG_MIRROR_MODE: mirror_reg = val[0];
        default: ;
      endcase
    endfunction

    function void note_input(logic cmd, logic [PIXEL_WIDTH-1:0] pix);
      int unsigned rows, cols, top, left, total, prow, pcol, sr, sc;
      padded_pixel_t want;
      rows  = sat(rows_reg, 1, MAX_ROWS);
      cols  = sat(cols_reg, 1, MAX_COLS);
      top   = sat(top_reg, 0, 64);
      left  = sat(left_reg, 0, 64);
      total = rows * cols;
      prow  = rows + top + sat(bottom_reg, 0, 64);
      pcol  = cols + left + sat(right_reg, 0, 64);
      want  = '0;
      if (cmd == CMD_LOAD) begin
        if (fill < total) begin
          store[fill] = pix;
          fill++;
          effective_items++;
        end
        return;
      end
      effective_items++;
      if (fill < total) begin
        want.early = 1'b1;
        pending.push_back(want);
        return;
      end
      if (mirror_reg) begin
        sr = reflect(cur_row, top, rows);
        sc = reflect(cur_col, left, cols);
        want.pixel = store[sr * cols + sc];
      end else if (cur_row >= top && cur_row - top < rows &&
                   cur_col >= left && cur_col - left < cols) begin
        want.pixel = store[(cur_row - top) * cols + (cur_col - left)];
      end
      want.row = POS_W'(cur_row);
      want.col = POS_W'(cur_col);
      cur_col++;
      if (cur_col >= pcol) begin
        cur_col = 0;
        cur_row++;
        if (cur_row >= prow) begin
          want.last = 1'b1;
          fill = 0;
          cur_row = 0;
          frames_done++;
        end
      end
      pending.push_back(want);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(padded_pixel_t got);
      padded_pixel_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected output transaction: expected none, actual pixel %0h",
                 $time, got.pixel);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("pixel_out", want.pixel, got.pixel);
      compare_field("out_row", want.row, got.row);
      compare_field("out_col", want.col, got.col);
      compare_field("frame_last", want.last, got.last);
      compare_field("not_ready", want.early, got.early);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   wr_en = 1'b0;
  logic [IDX_W-1:0]       wr_index = '0;
  logic [CFG_W-1:0]       wr_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   command = CMD_LOAD;
  logic [PIXEL_WIDTH-1:0] pixel_in = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [PIXEL_WIDTH-1:0] pixel_out;
  logic [POS_W-1:0]       out_row;
  logic [POS_W-1:0]       out_col;
  logic                   frame_last;
  logic                   not_ready;

  pad_scoreboard sb = new();
  padded_pixel_t observed;
  int            burst_left = 0;
  stall_mode_t   stall_mode = STALL_NONE;
  int            mode_left = 0;

  assign observed = {pixel_out, out_row, out_col, frame_last, not_ready};

  image_border_padder_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .pixel_in   (pixel_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_out  (pixel_out),
    .out_row    (out_row),
    .out_col    (out_col),
    .frame_last (frame_last),
    .not_ready  (not_ready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 2));
      mode_left <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE:   out_ready <= 1'b1;
      STALL_RANDOM: out_ready <= 1'($urandom_range(0, 1));
      default:      out_ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result(observed);
    end
  end

  function automatic logic [PIXEL_WIDTH-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIXEL_WIDTH'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic cmd, input logic [PIXEL_WIDTH-1:0] pix);
    int idle_cycles;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 16);
      idle_cycles = $urandom_range(0, 8);
      if (idle_cycles != 0) begin
        in_valid <= 1'b0;
        repeat (idle_cycles) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    command  <= cmd;
    pixel_in <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(cmd, pix);
  endtask

  // Drain outstanding reads and let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_config(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols,
                              input logic [CFG_W-1:0] top, input logic [CFG_W-1:0] bottom,
                              input logic [CFG_W-1:0] left, input logic [CFG_W-1:0] right,
                              input logic mirror);
    settle();
    write_reg(REG_IMAGE_ROWS, rows);
    write_reg(REG_IMAGE_COLS, cols);
    write_reg(REG_PAD_TOP, top);
    write_reg(REG_PAD_BOTTOM, bottom);
    write_reg(REG_PAD_LEFT, left);
    write_reg(REG_PAD_RIGHT, right);
    write_reg(REG_MIRROR_MODE, {{(CFG_W-1){1'b0}}, mirror});
    wr_en <= 1'b0;
  endtask

  // Load and read until the frame ends, or stop early after a given count
  task automatic run_frame(input int cut);
    int   sent;
    int   done_at_start;
    logic cmd;
    sent = 0;
    done_at_start = sb.frames_done;
    while (sb.frames_done == done_at_start && (cut == 0 || sent < cut)) begin
      if (!sb.frame_loaded()) begin
        cmd = ($urandom_range(0, 11) == 0) ? CMD_READ : CMD_LOAD;
      end else begin
        cmd = ($urandom_range(0, 19) == 0) ? CMD_LOAD : CMD_READ;
      end
      send_item(cmd, pick_pixel());
      sent++;
    end
  endtask

  initial begin
    logic [CFG_W-1:0] rows, cols;
    bit               wide;
    int               target;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(CMD_READ, '1);
    send_item(CMD_LOAD, '1);
    send_item(CMD_READ, '0);
    apply_config(7'd1, 7'd1, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0);
    run_frame(0);
    apply_config(7'd127, 7'd1, 7'd64, 7'd127, 7'd0, 7'd0, 1'b1);
    run_frame(0);
    apply_config(7'd0, 7'd64, 7'd0, 7'd0, 7'd64, 7'd100, 1'b0);
    run_frame(0);
    apply_config(7'd2, 7'd3, 7'd5, 7'd4, 7'd6, 7'd7, 1'b1);
    run_frame(0);
    apply_config(7'd3, 7'd3, 7'd1, 7'd1, 7'd1, 7'd1, 1'b0);
    run_frame(15);
    apply_config(7'd3, 7'd2, 7'd1, 7'd0, 7'd0, 7'd2, 1'b1);
    run_frame(0);

    target = 1100;
    while (sb.effective_items < target) begin
      wide = ($urandom_range(0, 5) == 0);
      if (wide) begin
        rows = CFG_W'($urandom_range(1, 3));
        cols = CFG_W'($urandom_range(1, 3));
      end else begin
        rows = ($urandom_range(0, 9) == 0) ? 7'd0 : CFG_W'($urandom_range(1, 8));
        cols = ($urandom_range(0, 9) == 0) ? 7'd0 : CFG_W'($urandom_range(1, 8));
      end
      apply_config(rows, cols,
                   CFG_W'($urandom_range(0, wide ? 12 : 3)),
                   CFG_W'($urandom_range(0, wide ? 12 : 3)),
                   CFG_W'($urandom_range(0, wide ? 12 : 3)),
                   CFG_W'($urandom_range(0, wide ? 12 : 3)),
                   1'($urandom_range(0, 1)));
      run_frame(($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : 0);
    end

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[image_border_padder_top] OK");
    end else begin
      $display("[image_border_padder_top] ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("[image_border_padder_top] ERROR");
    $finish;
  end

endmodule

[filelist.f]
hdl/ibp_pkg.sv
hdl/ibp_ctrl.sv
hdl/ibp_datapath.sv
hdl/image_border_padder_top.sv
tb/sv/image_border_padder_top_test.sv
